// File: rtl/core/jtsm_pkg.sv
// shared types and constants for the jtag tap shift master
`default_nettype none
package jtsm_pkg;

  localparam int IR_BITS_DEF = 8;
  localparam int DR_BITS_DEF = 16;
  localparam int ACTION_W    = 3;
  localparam int VALUE_W     = 16;
  localparam int WORD_W      = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 3'd0,
    ACT_SHIFT_IR = 3'd1,
    ACT_SHIFT_DR = 3'd2,
    ACT_TCLK_LO  = 3'd3,
    ACT_TCLK_HI  = 3'd4
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  shift_value;
    logic                tdo_level;
  } in_beat_t;

  typedef struct packed {
    logic              tck_pulse;
    logic              tms_level;
    logic              tdi_level;
    logic [WORD_W-1:0] captured_word;
    logic              shift_done;
    logic              busy_res;
    logic              command_ignored;
  } out_beat_t;

endpackage
`default_nettype wire

// File: rtl/core/jtsm_if.sv
// valid/ready channel interfaces for command and result beats
`default_nettype none
interface jtsm_in_if;
  logic                valid;
  logic                ready;
  jtsm_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jtsm_out_if;
  logic                valid;
  logic                ready;
  jtsm_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/jtsm_seq.sv
// tap walk sequencer: state registers and per-beat pin levels
`default_nettype none
module jtsm_seq #(
  parameter int IR_BITS = jtsm_pkg::IR_BITS_DEF,
  parameter int DR_BITS = jtsm_pkg::DR_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 accept,
  input  jtsm_pkg::in_beat_t  beat,
  output jtsm_pkg::out_beat_t result
);

  localparam int SHW    = (IR_BITS > DR_BITS) ? IR_BITS : DR_BITS;
  localparam int PH_TOP = ((IR_BITS + 4 > DR_BITS + 3) ? IR_BITS + 4 : DR_BITS + 3) + 1;
  localparam int PHW    = $clog2(PH_TOP + 1);

  logic [PHW-1:0] phase_r, phase_nxt;
  logic           is_data_r, is_data_nxt;
  logic [SHW-1:0] out_shift_r, out_shift_nxt;
  logic [SHW-1:0] capture_r, capture_nxt;
  logic           tclk_r, tclk_nxt;
  logic           active_r, active_nxt;

  logic [31:0]        val32;
  logic [SHW-1:0]     ir_load, dr_load;
  logic [SHW+15:0]    cap_ext;
  logic [PHW-1:0]     hdr, nb;

  assign val32   = {16'b0, beat.shift_value};
  // left-align so the msb always leaves from the top bit
  assign ir_load = SHW'(val32[IR_BITS-1:0]) << (SHW - IR_BITS);
  assign dr_load = SHW'(val32[DR_BITS-1:0]) << (SHW - DR_BITS);
  assign cap_ext = {16'b0, capture_r};
  assign hdr     = is_data_r ? PHW'(3) : PHW'(4);
  assign nb      = is_data_r ? PHW'(DR_BITS) : PHW'(IR_BITS);

  always_comb begin
    phase_nxt     = phase_r;
    is_data_nxt   = is_data_r;
    out_shift_nxt = out_shift_r;
    capture_nxt   = capture_r;
    tclk_nxt      = tclk_r;
    active_nxt    = active_r;
    result        = '0;
    result.tdi_level = tclk_r;
    case (beat.action)
      jtsm_pkg::ACT_TICK: begin
        if (active_r) begin
          result.tck_pulse = 1'b1;
          if (phase_r < hdr) begin
            result.tms_level = (phase_r < hdr - PHW'(2));
          end else if (phase_r < hdr + nb) begin
            result.tdi_level = out_shift_r[SHW-1];
            result.tms_level = (phase_r == hdr + nb - PHW'(1));
            out_shift_nxt    = out_shift_r << 1;
            capture_nxt      = {capture_r[SHW-2:0], beat.tdo_level};
          end else if (phase_r == hdr + nb) begin
            result.tms_level = 1'b1;
          end else begin
            result.shift_done    = 1'b1;
            result.captured_word = cap_ext[15:0];
            active_nxt           = 1'b0;
          end
          phase_nxt = active_nxt ? phase_r + PHW'(1) : '0;
        end
      end
      jtsm_pkg::ACT_SHIFT_IR, jtsm_pkg::ACT_SHIFT_DR: begin
        if (active_r) begin
          result.command_ignored = 1'b1;
        end else begin
          is_data_nxt   = (beat.action == jtsm_pkg::ACT_SHIFT_DR);
          out_shift_nxt = is_data_nxt ? dr_load : ir_load;
          capture_nxt   = '0;
          phase_nxt     = '0;
          active_nxt    = 1'b1;
        end
      end
      jtsm_pkg::ACT_TCLK_LO, jtsm_pkg::ACT_TCLK_HI: begin
        if (active_r) begin
          result.command_ignored = 1'b1;
        end else begin
          tclk_nxt = (beat.action == jtsm_pkg::ACT_TCLK_HI);
        end
        result.tdi_level = tclk_nxt;
      end
      default: begin
      end
    endcase
    result.busy_res = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      is_data_r <= 1'b0;
      tclk_r    <= 1'b0;
      active_r  <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      is_data_r <= is_data_nxt;
      tclk_r    <= tclk_nxt;
      active_r  <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_shift_r <= out_shift_nxt;
      capture_r   <= capture_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/jtsm_out_reg.sv
// result register with valid, frees itself when the beat is taken
`default_nettype none
module jtsm_out_reg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  jtsm_pkg::out_beat_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output jtsm_pkg::out_beat_t out_data
);

  logic                valid_r, valid_nxt;
  jtsm_pkg::out_beat_t data_r;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/jtag_tap_shift_master.sv
// top level of the jtag tap shift master
//
// One command beat in, one result beat out, one beat per clock sustained while the result sink keeps up.
// Each beat is a tick (one TCK low-high pulse on the target in a walk) or a
// command: shift an IR_BITS instruction, shift a DR_BITS data word, or set the
// TCLK level that TDI carries outside bit cycles. After a shift command the
// caller sends ticks; the result of each tick gives the TMS and TDI levels to
// drive and whether TCK pulses. An instruction walk takes IR_BITS+6 ticks, a
// data walk DR_BITS+5; the last tick of a walk reports shift_done with the
// TDO word collected (first bit received ends up most significant). Commands
// sent during a walk are dropped and flagged in command_ignored. The sequencer
// updates its counter and shift registers in the same cycle a beat is taken
// and the result sits in a single output register, so a new beat is taken
// every cycle the result register is empty or being emptied.
`default_nettype none
module jtag_tap_shift_master #(
  parameter int IR_BITS = jtsm_pkg::IR_BITS_DEF,
  parameter int DR_BITS = jtsm_pkg::DR_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  jtsm_in_if.sink    in_chan,
  jtsm_out_if.source out_chan
);

  // beat accepted by the sequencer this cycle
  logic                in_accept;
  logic                in_ready;
  // pin levels and status computed for the current beat
  jtsm_pkg::out_beat_t seq_result;

  assign in_chan.ready = in_ready;
  assign in_accept     = in_chan.valid && in_ready;

  // walk state and combinational pin levels
  jtsm_seq #(
    .IR_BITS (IR_BITS),
    .DR_BITS (DR_BITS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .beat   (in_chan.data),
    .result (seq_result)
  );

  // output register, decouples the result sink from the command source
  jtsm_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .in_data   (seq_result),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data)
  );

endmodule
`default_nettype wire
